[hw/rtl/jcp_pkg.sv]
// Package: probe phase codes, fixed TMS walks and the IDCODE check.
`timescale 1ns / 1ps
package jcp_pkg;

  localparam int unsigned PhaseW = 4;

  localparam logic [PhaseW-1:0] PH_IDLE    = 4'd0;
  localparam logic [PhaseW-1:0] PH_D_WALK  = 4'd1;
  localparam logic [PhaseW-1:0] PH_D_FILL  = 4'd2;
  localparam logic [PhaseW-1:0] PH_D_TOSDR = 4'd3;
  localparam logic [PhaseW-1:0] PH_D_COUNT = 4'd4;
  localparam logic [PhaseW-1:0] PH_D_EXIT  = 4'd5;
  localparam logic [PhaseW-1:0] PH_B_WALK  = 4'd6;
  localparam logic [PhaseW-1:0] PH_B_FILL  = 4'd7;
  localparam logic [PhaseW-1:0] PH_B_TOSDR = 4'd8;
  localparam logic [PhaseW-1:0] PH_B_SHIFT = 4'd9;
  localparam logic [PhaseW-1:0] PH_B_EXIT  = 4'd10;
  localparam logic [PhaseW-1:0] PH_C_WALK  = 4'd11;
  localparam logic [PhaseW-1:0] PH_C_READ  = 4'd12;
  localparam logic [PhaseW-1:0] PH_C_EXIT  = 4'd13;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [6:0] MfrCodeMax = 7'd126;
  localparam logic [3:0] BankMax    = 4'd8;

  typedef struct packed {
    logic [15:0] mask;
    logic [3:0]  len;
    logic        tdi;
  } walk_t;

  function automatic walk_t walk_of(logic [PhaseW-1:0] ph);
    walk_t w;
    w.mask = 16'h0000;
    w.len  = 4'd1;
    w.tdi  = 1'b0;
    unique case (ph)
      PH_D_WALK:  begin w.mask = 16'h00DF; w.len = 4'd10; end
      PH_D_TOSDR: begin w.mask = 16'h0007; w.len = 4'd5; w.tdi = 1'b1; end
      PH_D_EXIT:  begin w.mask = 16'h0003; w.len = 4'd3; end
      PH_B_WALK:  begin w.mask = 16'h00DF; w.len = 4'd10; end
      PH_B_TOSDR: begin w.mask = 16'h000B; w.len = 4'd6; w.tdi = 1'b1; end
      PH_B_EXIT:  begin w.mask = 16'h0001; w.len = 4'd2; end
      PH_C_WALK:  begin w.mask = 16'h005F; w.len = 4'd9; end
      PH_C_EXIT:  begin w.mask = 16'h001F; w.len = 4'd6; w.tdi = 1'b1; end
      default:    begin end
    endcase
    return w;
  endfunction

  function automatic logic id_valid(logic [31:0] id);
    logic [6:0] code;
    logic [3:0] bank;
    code = {1'b0, id[6:1]};
    bank = id[11:8];
    return (code > 7'd1) && (code <= MfrCodeMax) && (bank <= BankMax);
  endfunction

endpackage

[hw/rtl/jcp_if.sv]
// Interfaces: input tick beat and result beat channels.
`timescale 1ns / 1ps
interface jcp_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] pattern;
  logic        tdo;

  modport source (output valid, output cmd, output pattern, output tdo, input ready);
  modport sink   (input valid, input cmd, input pattern, input tdo, output ready);
endinterface

interface jcp_out_if;
  logic        valid;
  logic        ready;
  logic        tms;
  logic        tdi;
  logic        busy_res;
  logic        id_ready;
  logic [31:0] id_value;
  logic        done_res;
  logic        found;
  logic [4:0]  device_count;

  modport source (output valid, output tms, output tdi, output busy_res, output id_ready,
                  output id_value, output done_res, output found, output device_count,
                  input ready);
  modport sink   (input valid, input tms, input tdi, input busy_res, input id_ready,
                  input id_value, input done_res, input found, input device_count,
                  output ready);
endinterface

[hw/rtl/jtag_chain_probe.sv]
// Top level: JTAG chain detect, bypass check and IDCODE scan sequencer.
// The result beat of an accepted input beat is registered and offered in the cycle after it.
// Throughput: one beat per cycle while the sink takes results; the result register frees as the sink takes it.
// Each beat is one TCK period; the phase sequencer updates in the accepting cycle.
// Reset: asynchronous, active low; the sequencer returns to idle, no result held.
`timescale 1ns / 1ps
module jtag_chain_probe
  import jcp_pkg::*;
#(
  parameter int unsigned MAX_DEVICES        = 32,
  parameter int unsigned IR_BITS_PER_DEVICE = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  jcp_in_if.sink     in_i,
  jcp_out_if.source  out_o
);

  localparam int unsigned FillLen  = MAX_DEVICES * IR_BITS_PER_DEVICE;
  localparam int unsigned ReadLen  = (MAX_DEVICES - 2) * 32;
  localparam int unsigned ShiftLen = 32 + MAX_DEVICES;
  localparam int unsigned LenMax01 = (FillLen > ReadLen) ? FillLen : ReadLen;
  localparam int unsigned LenMax   = (LenMax01 > ShiftLen) ? LenMax01 : ShiftLen;
  localparam int unsigned CntW     = $clog2(LenMax);
  localparam int unsigned LenW     = CntW + 1;
  localparam int unsigned CcW      = $clog2(MAX_DEVICES);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [CntW-1:0]   tick_q, tick_d;
  logic [CcW-1:0]    cc_q, cc_d;
  logic [31:0]       test_q, test_d;
  logic [31:0]       shift_q, shift_d;
  logic              id_seen_q, id_seen_d;
  logic              first_ok_q, first_ok_d;

  logic              out_valid_q;
  logic              tms_q, tdi_q, busy_q, idr_q, done_q, fnd_q;
  logic [31:0]       idv_q;
  logic [4:0]        dc_q;

  logic              tms, tdi, busy, idr, done, fnd;
  logic [31:0]       idv;
  logic [4:0]        dc;

  logic              accept;
  logic [LenW-1:0]   len;
  logic [LenW-1:0]   t_next;
  logic [LenW-1:0]   ones;
  logic              ended;
  logic [PhaseW-1:0] nxt;
  walk_t             walk;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign accept     = in_i.valid & in_i.ready;
  assign t_next     = LenW'(tick_q) + LenW'(1);
  assign ones       = LenW'(tick_q) + LenW'(in_i.tdo);
  assign walk       = walk_of(phase_q);

  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    cc_d       = cc_q;
    test_d     = test_q;
    shift_d    = shift_q;
    id_seen_d  = id_seen_q;
    first_ok_d = first_ok_q;
    tms  = 1'b0;
    tdi  = 1'b0;
    busy = 1'b0;
    idr  = 1'b0;
    idv  = '0;
    done = 1'b0;
    fnd  = 1'b0;
    dc   = '0;
    len  = LenW'(1);
    ended = 1'b0;
    nxt  = phase_q;

    if (in_i.cmd == CMD_START) begin
      phase_d    = PH_D_WALK;
      tick_d     = '0;
      cc_d       = '0;
      test_d     = in_i.pattern;
      shift_d    = '0;
      id_seen_d  = 1'b0;
      first_ok_d = 1'b0;
      busy       = 1'b1;
    end else if (phase_q != PH_IDLE) begin
      unique case (phase_q)
        PH_D_FILL: begin
          len = LenW'(FillLen);
          tdi = 1'b1;
        end
        PH_D_COUNT: begin
          len = LenW'(MAX_DEVICES - 1);
        end
        PH_B_FILL: begin
          len = LenW'(cc_q) * LenW'(IR_BITS_PER_DEVICE);
          tdi = 1'b1;
        end
        PH_B_SHIFT: begin
          len = LenW'(32) + LenW'(cc_q);
          tdi = (tick_q < CntW'(32)) ? test_q[tick_q[4:0]] : 1'b0;
          tms = (t_next >= len);
        end
        PH_C_READ: begin
          len = LenW'(cc_q) << 5;
          tdi = 1'b1;
        end
        default: begin
          len = LenW'(walk.len);
          tdi = walk.tdi;
          tms = (tick_q < CntW'(16)) ? walk.mask[tick_q[3:0]] : 1'b0;
        end
      endcase
      ended = (t_next >= len);

      case (phase_q)
        PH_D_COUNT: begin
          if (!in_i.tdo || ended) begin
            cc_d  = (ones < LenW'(MAX_DEVICES - 1)) ? CcW'(ones) : '0;
            ended = 1'b1;
          end
        end
        PH_B_SHIFT: begin
          shift_d = {in_i.tdo, shift_q[31:1]};
        end
        PH_C_READ: begin
          shift_d = {in_i.tdo, shift_q[31:1]};
          if (tick_q[4:0] == 5'd31) begin
            idr       = 1'b1;
            idv       = shift_d;
            id_seen_d = 1'b1;
            if (!id_seen_q) begin
              first_ok_d = id_valid(shift_d);
            end
          end
        end
        default: begin
        end
      endcase

      if (ended) begin
        unique case (phase_q)
          PH_D_EXIT: begin
            if (cc_d == '0) begin
              done = 1'b1;
              nxt  = PH_IDLE;
            end else begin
              nxt = PH_B_WALK;
            end
          end
          PH_B_EXIT: begin
            if (shift_d == test_q) begin
              nxt = PH_C_WALK;
            end else begin
              done = 1'b1;
              nxt  = PH_IDLE;
            end
          end
          PH_C_EXIT: begin
            done = 1'b1;
            fnd  = first_ok_d;
            nxt  = PH_IDLE;
          end
          default: begin
            nxt = phase_q + PhaseW'(1);
          end
        endcase
        if (nxt == PH_B_SHIFT || nxt == PH_C_READ) begin
          shift_d = '0;
        end
        phase_d = nxt;
        tick_d  = '0;
      end else begin
        tick_d = t_next[CntW-1:0];
      end
      if (done) begin
        dc = 5'(cc_d);
      end
      busy = (phase_d != PH_IDLE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      tick_q     <= '0;
      cc_q       <= '0;
      test_q     <= '0;
      shift_q    <= '0;
      id_seen_q  <= 1'b0;
      first_ok_q <= 1'b0;
    end else if (accept) begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      cc_q       <= cc_d;
      test_q     <= test_d;
      shift_q    <= shift_d;
      id_seen_q  <= id_seen_d;
      first_ok_q <= first_ok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tms_q  <= tms;
      tdi_q  <= tdi;
      busy_q <= busy;
      idr_q  <= idr;
      idv_q  <= idv;
      done_q <= done;
      fnd_q  <= fnd;
      dc_q   <= dc;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.tms          = tms_q;
  assign out_o.tdi          = tdi_q;
  assign out_o.busy_res     = busy_q;
  assign out_o.id_ready     = idr_q;
  assign out_o.id_value     = idv_q;
  assign out_o.done_res     = done_q;
  assign out_o.found        = fnd_q;
  assign out_o.device_count = dc_q;

endmodule

[test/tb_jtag_chain_probe.sv]
`timescale 1ns / 1ps
// Testbench: jtag_chain_probe run against a simulated scan chain, every result beat predicted.
module tb_jtag_chain_probe;
  import jcp_pkg::*;

  localparam int unsigned MaxDevices = 32;
  localparam int unsigned IrBits     = 32;
  localparam int unsigned ItemTarget = 1600;

  typedef struct packed {
    logic        tms;
    logic        tdi;
    logic        busy;
    logic        id_ready;
    logic [31:0] id_value;
    logic        done;
    logic        found;
    logic [4:0]  device_count;
  } probe_res_t;

  typedef enum int {
    RunClean, RunNoChain, RunEmpty, RunBadBypass, RunAbort, RunNoise
  } run_kind_e;

  class probe_scoreboard;
    logic [PhaseW-1:0] phase;
    int unsigned       tick_no;
    int unsigned       chain_len;
    int unsigned       id_count;
    logic [31:0]       bypass_word;
    logic [31:0]       tdo_word;
    bit                first_id_good;
    probe_res_t        due_results[$];
    int unsigned       mismatches;

    function new();
      phase         = PH_IDLE;
      tick_no       = 0;
      chain_len     = 0;
      id_count      = 0;
      bypass_word   = '0;
      tdo_word      = '0;
      first_id_good = 1'b0;
      mismatches    = 0;
    endfunction

    function bit idcode_plausible(logic [31:0] id);
      return (id[6:1] >= 6'd2) && (id[11:8] <= 4'd8);
    endfunction

    function void note_beat(logic cmd, logic [31:0] pattern, logic tdo);
      probe_res_t        r;
      int unsigned       t;
      int unsigned       len;
      int unsigned       ones;
      logic [15:0]       walk;
      bit                last;
      logic [PhaseW-1:0] nxt;
      r    = '0;
      t    = tick_no;
      len  = 1;
      walk = '0;
      nxt  = phase;
      if (cmd == CMD_START) begin
        phase         = PH_D_WALK;
        tick_no       = 0;
        chain_len     = 0;
        bypass_word   = pattern;
        tdo_word      = '0;
        id_count      = 0;
        first_id_good = 1'b0;
        r.busy        = 1'b1;
      end else if (phase != PH_IDLE) begin
        case (phase)
          PH_D_WALK, PH_B_WALK: begin
            walk = 16'h00DF;
            len  = 10;
          end
          PH_D_FILL: begin
            len   = MaxDevices * IrBits;
            r.tdi = 1'b1;
          end
          PH_D_TOSDR: begin
            walk  = 16'h0007;
            len   = 5;
            r.tdi = 1'b1;
          end
          PH_D_COUNT: len = MaxDevices - 1;
          PH_D_EXIT: begin
            walk = 16'h0003;
            len  = 3;
          end
          PH_B_FILL: begin
            len   = chain_len * IrBits;
            r.tdi = 1'b1;
          end
          PH_B_TOSDR: begin
            walk  = 16'h000B;
            len   = 6;
            r.tdi = 1'b1;
          end
          PH_B_SHIFT: begin
            len = 32 + chain_len;
            if (t < 32) r.tdi = bypass_word[t];
          end
          PH_B_EXIT: begin
            walk = 16'h0001;
            len  = 2;
          end
          PH_C_WALK: begin
            walk = 16'h005F;
            len  = 9;
          end
          PH_C_READ: begin
            len   = chain_len * 32;
            r.tdi = 1'b1;
          end
          PH_C_EXIT: begin
            walk  = 16'h001F;
            len   = 6;
            r.tdi = 1'b1;
          end
          default: begin
          end
        endcase
        last = (t + 1 >= len);
        if (phase == PH_B_SHIFT) r.tms = last;
        else if (t < 16) r.tms = walk[t];

        case (phase)
          PH_D_COUNT: begin
            if (!tdo || last) begin
              ones      = t + tdo;
              chain_len = (ones < MaxDevices - 1) ? ones : 0;
              last      = 1'b1;
            end
          end
          PH_B_SHIFT: tdo_word = {tdo, tdo_word[31:1]};
          PH_C_READ: begin
            tdo_word = {tdo, tdo_word[31:1]};
            if (t % 32 == 31) begin
              r.id_ready = 1'b1;
              r.id_value = tdo_word;
              if (id_count == 0) first_id_good = idcode_plausible(tdo_word);
              id_count = (id_count + 1) % 64;
            end
          end
          default: begin
          end
        endcase

        if (last) begin
          case (phase)
            PH_D_EXIT: begin
              if (chain_len == 0) begin
                r.done = 1'b1;
                nxt    = PH_IDLE;
              end else begin
                nxt = PH_B_WALK;
              end
            end
            PH_B_EXIT: begin
              if (tdo_word == bypass_word) begin
                nxt = PH_C_WALK;
              end else begin
                r.done = 1'b1;
                nxt    = PH_IDLE;
              end
            end
            PH_C_EXIT: begin
              r.done  = 1'b1;
              r.found = first_id_good;
              nxt     = PH_IDLE;
            end
            default: nxt = phase + 1'b1;
          endcase
          if (nxt == PH_B_SHIFT || nxt == PH_C_READ) tdo_word = '0;
          phase   = nxt;
          tick_no = 0;
        end else begin
          tick_no = (t + 1) % 2048;
        end
        if (r.done) r.device_count = chain_len[4:0];
        r.busy = (phase != PH_IDLE);
      end
      due_results = {due_results, r};
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(probe_res_t got);
      probe_res_t want;
      if (due_results.size() == 0) begin
        $error("result beat with nothing due");
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      compare("tms", want.tms, got.tms);
      compare("tdi", want.tdi, got.tdi);
      compare("busy_res", want.busy, got.busy);
      compare("id_ready", want.id_ready, got.id_ready);
      compare("id_value", want.id_value, got.id_value);
      compare("done_res", want.done, got.done);
      compare("found", want.found, got.found);
      compare("device_count", want.device_count, got.device_count);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  jcp_in_if  in_if ();
  jcp_out_if out_if ();

  jtag_chain_probe #(
    .MAX_DEVICES       (MaxDevices),
    .IR_BITS_PER_DEVICE(IrBits)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  probe_scoreboard sb;
  int unsigned     probe_items;
  int              chain_devs;
  int              flip_bit;
  bit              noisy;
  logic [31:0]     chain_ids [MaxDevices];

  always #5 clk_i = ~clk_i;

  function automatic logic chain_tdo();
    int k;
    if (noisy) return 1'($urandom_range(0, 1));
    case (sb.phase)
      PH_D_COUNT: return (sb.tick_no < chain_devs) ? 1'b1 : 1'b0;
      PH_B_SHIFT: begin
        k = int'(sb.tick_no) - chain_devs;
        if (k >= 0 && k < 32) return sb.bypass_word[k] ^ (k == flip_bit);
      end
      PH_C_READ: return chain_ids[sb.tick_no / 32][sb.tick_no % 32];
      default: begin
      end
    endcase
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic send_beat(input logic cmd, input logic [31:0] pattern, input logic tdo);
    int unsigned gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.cmd     <= cmd;
    in_if.pattern <= pattern;
    in_if.tdo     <= tdo;
    in_if.valid   <= 1'b1;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    sb.note_beat(cmd, pattern, tdo);
    probe_items++;
  endtask

  task automatic run_probe(input run_kind_e kind, input int devs_hint);
    int unsigned cap;
    int unsigned n;
    int unsigned r;
    logic [31:0] pattern;
    if ($urandom_range(0, 2) == 0 || kind == RunEmpty) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while (sb.due_results.size() != 0);
    end
    noisy    = (kind == RunNoise);
    flip_bit = -1;
    cap      = 100000;
    if (sb.phase == PH_IDLE) begin
      repeat ($urandom_range(0, 2)) send_beat(CMD_TICK, $urandom(), 1'($urandom_range(0, 1)));
    end
    r = $urandom_range(0, 99);
    case (kind)
      RunNoChain: chain_devs = MaxDevices - 1;
      RunEmpty:   chain_devs = 0;
      default: begin
        if (devs_hint > 0) chain_devs = devs_hint;
        else if (r < 70) chain_devs = $urandom_range(1, 3);
        else if (r < 92) chain_devs = $urandom_range(4, 12);
        else chain_devs = $urandom_range(13, MaxDevices - 2);
      end
    endcase
    if (kind == RunBadBypass) flip_bit = $urandom_range(0, 31);
    if (kind == RunAbort) cap = $urandom_range(1, 1100 + 70 * chain_devs);
    foreach (chain_ids[i]) chain_ids[i] = $urandom();
    case ($urandom_range(0, 7))
      0: chain_ids[0] = '0;
      1: chain_ids[0] = '1;
      2: begin
      end
      default: begin
        chain_ids[0][0]    = 1'b1;
        chain_ids[0][6:1]  = 6'($urandom_range(2, 63));
        chain_ids[0][11:8] = 4'($urandom_range(0, 8));
      end
    endcase
    case ($urandom_range(0, 9))
      0:       pattern = '0;
      1:       pattern = '1;
      default: pattern = $urandom();
    endcase
    send_beat(CMD_START, pattern, 1'($urandom_range(0, 1)));
    n = 0;
    while (sb.phase != PH_IDLE && n < cap && probe_items < ItemTarget) begin
      send_beat(CMD_TICK, $urandom(), chain_tdo());
      n++;
    end
  endtask

  initial begin : stimulus
    sb = new();
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.cmd     <= CMD_TICK;
    in_if.pattern <= '0;
    in_if.tdo     <= 1'b0;
    probe_items = 0;
    chain_devs  = 0;
    flip_bit    = -1;
    noisy       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_beat(CMD_TICK, '0, 1'b0);
    send_beat(CMD_TICK, '1, 1'b1);
    send_beat(CMD_START, '0, 1'b1);
    repeat (4) send_beat(CMD_TICK, $urandom(), 1'($urandom_range(0, 1)));
    send_beat(CMD_START, '1, 1'b0);
    repeat (12) send_beat(CMD_TICK, '1, 1'b1);
    send_beat(CMD_START, 32'hA5A5_5A5A, 1'b1);

    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.due_results.size() != 0);

    run_probe(RunClean, 1);
    while (probe_items < ItemTarget) run_probe(run_kind_e'($urandom_range(0, 5)), 0);

    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.due_results.size() != 0);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("jtag_chain_probe regression: pass");
    end else begin
      $display("jtag_chain_probe regression: fail");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned stall;
    int unsigned taken;
    probe_res_t  got;
    out_if.ready <= 1'b0;
    taken = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = (taken == 1500) ? 400 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
      got = '{tms: out_if.tms, tdi: out_if.tdi, busy: out_if.busy_res,
              id_ready: out_if.id_ready, id_value: out_if.id_value,
              done: out_if.done_res, found: out_if.found,
              device_count: out_if.device_count};
      sb.check_result(got);
      taken++;
    end
  end

  initial begin : watchdog
    #(64'd20_000_000);
    $display("jtag_chain_probe regression: fail");
    $finish;
  end

endmodule
